/* src/dtsp_pkg.sv */
// Package for the dimension text to scaled points unit.
// Types, constants and lookup functions shared by the parser, the
// arithmetic unit and the top level. No dependencies.
package dtsp_pkg;

    localparam int CHAR_W    = 8;
    localparam int INT_W     = 30;
    localparam int NUM_W     = 15;
    localparam int STEP_W    = 3;
    localparam int CODE_W    = 4;
    localparam int COUNT_W   = 8;
    localparam int MUL_A_W   = 30;
    localparam int MUL_B_W   = 23;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 54;
    localparam int DIV_W     = 30;
    localparam int DVS_W     = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int OUT_W     = 72;

    localparam logic [INT_W-1:0] INT_MAX_VAL   = INT_W'(999999999);
    localparam logic [INT_W-1:0] INT_OVF_LIMIT = INT_W'(100000000);
    localparam logic [INT_W-1:0] INT_DEFAULT   = INT_W'(10);
    localparam logic [ACC_W-1:0] ACC_OVF_LIMIT = ACC_W'(64'h4000_0000);

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

    localparam logic [CODE_W-1:0] UNIT_IN = 4'd8;

    typedef enum logic [2:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_SP1,
        PH_KEY,
        PH_SP2,
        PH_UNIT1,
        PH_UNIT2
    } dtsp_phase_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_LOAD1,
        SQ_DIV1,
        SQ_MULW,
        SQ_MULF,
        SQ_MULR,
        SQ_LOAD2,
        SQ_DIV2,
        SQ_ADDQ,
        SQ_OUT
    } dtsp_seq_t;

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add_prod;
        logic acc_add_quo;
        logic div_load;
        logic div_step;
    } dtsp_ctl_t;

    typedef struct packed {
        logic               neg;
        logic [INT_W-1:0]   int_part;
        logic               digit_seen;
        logic [NUM_W-1:0]   frac_num;
        logic [STEP_W-1:0]  den_step;
        logic               kw_found;
        logic [CODE_W-1:0]  unit_code;
        logic               unit_known;
        logic [COUNT_W-1:0] count;
        logic               ovf;
    } dtsp_parse_t;

    // Scale factor in scaled points per unit.
    function automatic logic [MUL_B_W-1:0] scale_of(input logic [CODE_W-1:0] code);
        logic [MUL_B_W-1:0] s;
        case (code)
            4'd0:    s = MUL_B_W'(1864680);
            4'd1:    s = MUL_B_W'(65536);
            4'd2:    s = MUL_B_W'(786432);
            4'd3:    s = MUL_B_W'(186468);
            4'd4:    s = MUL_B_W'(1);
            4'd5:    s = MUL_B_W'(65782);
            4'd6:    s = MUL_B_W'(70124);
            4'd7:    s = MUL_B_W'(841489);
            default: s = MUL_B_W'(4736286);
        endcase
        return s;
    endfunction

    function automatic logic [NUM_W-1:0] den_of(input logic [STEP_W-1:0] step);
        logic [NUM_W-1:0] d;
        case (step)
            3'd0:    d = NUM_W'(1);
            3'd1:    d = NUM_W'(10);
            3'd2:    d = NUM_W'(100);
            3'd3:    d = NUM_W'(1000);
            3'd4:    d = NUM_W'(10000);
            default: d = NUM_W'(20000);
        endcase
        return d;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            2'd0:    c = 8'h74;
            2'd1:    c = 8'h72;
            2'd2:    c = 8'h75;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

    // cm pt pc mm sp bp dd cc in
    localparam logic [8:0][15:0] UNIT_PAIRS = {
        16'h696E, 16'h6363, 16'h6464, 16'h6270, 16'h7370,
        16'h6D6D, 16'h7063, 16'h7074, 16'h636D
    };

    // Returns {hit, code}.
    function automatic logic [CODE_W:0] unit_lookup(input logic [CHAR_W-1:0] a,
                                                    input logic [CHAR_W-1:0] b);
        logic              hit;
        logic [CODE_W-1:0] code;
        hit  = 1'b0;
        code = UNIT_IN;
        for (int i = 0; i < 9; i++) begin
            if (!hit && UNIT_PAIRS[i] == {a, b}) begin
                hit  = 1'b1;
                code = CODE_W'(i);
            end
        end
        return {hit, code};
    endfunction

endpackage

/* src/dimension_text_to_scaled_points_unit.sv */
// Top level of the dimension text to scaled points unit: stream ports,
// sequencer and output register. Depends on dtsp_pkg, dtsp_parse, dtsp_alu.
//
// Each byte of the dimension text is one request on the s_ side. After the
// byte marked with s_tlast the block stops taking requests while a single
// shared multiplier, accumulator and bit-serial divider work out the value:
// one 30-step division of the unit scale by the fraction denominator, three
// multiplies, and one 30-step division for the rounding term. The result
// then sits in an output register until taken; a new dimension may start as
// soon as it is loaded.
module dimension_text_to_scaled_points_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // char_code
    input  logic                         s_tlast,   // last_char
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // scaled_value, unit_code, true_seen, overflow_seen, number_missing,
    // unit_missing, chars_used, zero pad
    output logic [dtsp_pkg::OUT_W-1:0]   m_tdata
);
    import dtsp_pkg::*;

    dtsp_seq_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    dtsp_parse_t           p;
    dtsp_ctl_t             ctl;
    logic                  take;
    logic                  out_load;
    logic [NUM_W-1:0]      den;
    logic [NUM_W-1:0]      num_c;
    logic [MUL_B_W-1:0]    sf;
    logic [INT_W-1:0]      whole;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [DIV_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic [ACC_W-1:0]      acc;
    logic [PROD_W-1:0]     prod;
    logic [DIV_W-1:0]      quo;
    logic [DVS_W-1:0]      rem;
    logic [ACC_W-1:0]      value;

    assign s_tready = (state_reg == SQ_IDLE);
    assign take     = s_tvalid && s_tready;
    assign out_load = (state_reg == SQ_OUT) && (!m_tvalid_reg || m_tready);

    dtsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .char_code (s_tdata),
        .clr       (out_load),
        .p         (p)
    );

    assign den   = den_of(p.den_step);
    assign num_c = (p.frac_num >= den) ? den - NUM_W'(1) : p.frac_num;
    assign sf    = scale_of(p.unit_code);
    assign whole = p.digit_seen ? p.int_part : INT_DEFAULT;

    dtsp_alu u_alu (
        .clk          (clk),
        .ctl          (ctl),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .acc          (acc),
        .prod         (prod),
        .quo          (quo),
        .rem          (rem)
    );

    always_comb
    begin
        case (state_reg)
            SQ_MULF:
            begin
                mul_a = MUL_A_W'(num_c);
                mul_b = quo[MUL_B_W-1:0];
            end
            SQ_MULR:
            begin
                mul_a = MUL_A_W'(num_c);
                mul_b = MUL_B_W'(rem);
            end
            default:
            begin
                mul_a = MUL_A_W'(whole);
                mul_b = sf;
            end
        endcase

        if (state_reg == SQ_LOAD2)
        begin
            div_dividend = {prod[DIV_W-2:0], 1'b0} + DIV_W'(den);
            div_divisor  = {den, 1'b0};
        end
        else
        begin
            div_dividend = DIV_W'(sf);
            div_divisor  = DVS_W'(den);
        end
    end

    assign value = p.neg ? ACC_W'(0) - acc : acc;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        ctl           = '0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            SQ_IDLE:
                if (take && s_tlast)
                    state_next = SQ_LOAD1;
            SQ_LOAD1:
            begin
                ctl.div_load = 1'b1;
                ctl.acc_clr  = 1'b1;
                cnt_next     = '0;
                state_next   = SQ_DIV1;
            end
            SQ_DIV1:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                    state_next = SQ_MULW;
            end
            SQ_MULW:
            begin
                ctl.mul_en = 1'b1;
                state_next = SQ_MULF;
            end
            SQ_MULF:
            begin
                ctl.mul_en       = 1'b1;
                ctl.acc_add_prod = 1'b1;
                state_next       = SQ_MULR;
            end
            SQ_MULR:
            begin
                ctl.mul_en       = 1'b1;
                ctl.acc_add_prod = 1'b1;
                state_next       = SQ_LOAD2;
            end
            SQ_LOAD2:
            begin
                ctl.div_load = 1'b1;
                ovf_next     = p.ovf || (acc > ACC_OVF_LIMIT);
                cnt_next     = '0;
                state_next   = SQ_DIV2;
            end
            SQ_DIV2:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                    state_next = SQ_ADDQ;
            end
            SQ_ADDQ:
            begin
                ctl.acc_add_quo = 1'b1;
                state_next      = SQ_OUT;
            end
            SQ_OUT:
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, p.count, ~p.unit_known, ~p.digit_seen,
                                     ovf_reg, p.kw_found, p.unit_code, value};
                    state_next    = SQ_IDLE;
                end
            default:
                state_next = SQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SQ_IDLE;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tlast) |=> (state_reg == SQ_LOAD1))
        else $error("last request did not start the computation");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_DIV1 && cnt_reg == DIV_CNT_W'(DIV_W - 1)) |=>
        (state_reg == SQ_MULW))
        else $error("first division did not end after its step count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while holding a result");

    a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && p.count == '0 && !p.ovf && !p.unit_known))
        else $error("parser not cleared after result load");

endmodule

/* src/dtsp_parse.sv */
// Character parser: one byte per request into sign, integer, fraction,
// keyword and unit state. Depends on dtsp_pkg.
module dtsp_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [dtsp_pkg::CHAR_W-1:0] char_code,
    input  logic                      clr,
    output dtsp_pkg::dtsp_parse_t     p
);
    import dtsp_pkg::*;

    dtsp_phase_t         phase_reg, phase_next;
    logic                finished_reg, finished_next;
    logic                neg_reg, neg_next;
    logic [INT_W-1:0]    int_reg, int_next;
    logic                digit_reg, digit_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [2:0]          kidx_reg, kidx_next;
    logic                kw_reg, kw_next;
    logic [CHAR_W-1:0]   first_reg, first_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [CODE_W-1:0]   usel_reg, usel_next;
    logic                uknown_reg, uknown_next;

    dtsp_phase_t         eph;
    logic                is_dig;
    logic [3:0]          dig;
    logic [INT_W+3:0]    nv;
    logic [CODE_W:0]     uhit;
    logic [2:0]          inc;
    logic [COUNT_W:0]    cnt_sum;

    always_comb
    begin
        phase_next    = phase_reg;
        finished_next = finished_reg;
        neg_next      = neg_reg;
        int_next      = int_reg;
        digit_next    = digit_reg;
        num_next      = num_reg;
        step_next     = step_reg;
        kidx_next     = kidx_reg;
        kw_next       = kw_reg;
        first_next    = first_reg;
        ovf_next      = ovf_reg;
        usel_next     = usel_reg;
        uknown_next   = uknown_reg;
        inc           = 3'd0;
        eph           = phase_reg;
        is_dig        = char_code inside {[CH_0:CH_9]};
        dig           = char_code[3:0];
        nv            = {1'b0, int_reg, 3'b000} + {3'b000, int_reg, 1'b0} +
                        (INT_W+4)'(dig);
        uhit          = unit_lookup(first_reg, char_code);

        if (take && !finished_reg)
        begin
            if (eph == PH_START && char_code != CH_MINUS)
                eph = PH_INT;
            if (eph == PH_INT && !is_dig && char_code != CH_DOT)
                eph = PH_SP1;
            if (eph == PH_FRAC && !is_dig)
                eph = PH_SP1;
            if (eph == PH_SP1 && char_code != CH_SPACE && char_code != CH_T)
                eph = PH_UNIT1;
            if (eph == PH_SP2 && char_code != CH_SPACE)
                eph = PH_UNIT1;

            case (eph)
                PH_START:
                begin
                    phase_next = PH_INT;
                    neg_next   = 1'b1;
                    inc        = 3'd1;
                end
                PH_INT:
                begin
                    if (is_dig)
                    begin
                        phase_next = PH_INT;
                        if (int_reg > INT_OVF_LIMIT)
                            ovf_next = 1'b1;
                        if (nv > (INT_W+4)'(INT_MAX_VAL))
                        begin
                            int_next = INT_MAX_VAL;
                            ovf_next = 1'b1;
                        end
                        else
                            int_next = nv[INT_W-1:0];
                        digit_next = 1'b1;
                    end
                    else
                        phase_next = PH_FRAC;
                    inc = 3'd1;
                end
                PH_FRAC:
                begin
                    phase_next = PH_FRAC;
                    if (step_reg <= 3'd3)
                    begin
                        num_next  = NUM_W'({num_reg, 3'b000} + {2'b00, num_reg, 1'b0} +
                                           18'(dig));
                        step_next = step_reg + 3'd1;
                    end
                    else if (step_reg == 3'd4)
                    begin
                        num_next  = {num_reg[NUM_W-2:0], 1'b0} + NUM_W'(dig >= 4'd5);
                        step_next = 3'd5;
                    end
                    inc = 3'd1;
                end
                PH_SP1:
                begin
                    if (char_code == CH_SPACE)
                    begin
                        phase_next = PH_SP1;
                        inc        = 3'd1;
                    end
                    else
                    begin
                        kidx_next  = 3'd1;
                        phase_next = PH_KEY;
                    end
                end
                PH_KEY:
                begin
                    if (char_code == kw_char(kidx_reg[1:0]))
                    begin
                        kidx_next = kidx_reg + 3'd1;
                        if (kidx_reg == 3'd3)
                        begin
                            kw_next    = 1'b1;
                            inc        = 3'd4;
                            phase_next = PH_SP2;
                        end
                    end
                    else
                        finished_next = 1'b1;
                end
                PH_SP2:
                begin
                    phase_next = PH_SP2;
                    inc        = 3'd1;
                end
                PH_UNIT1:
                begin
                    first_next = char_code;
                    phase_next = PH_UNIT2;
                end
                PH_UNIT2:
                begin
                    if (uhit[CODE_W])
                    begin
                        usel_next   = uhit[CODE_W-1:0];
                        uknown_next = 1'b1;
                        inc         = 3'd2;
                    end
                    finished_next = 1'b1;
                end
                default:
                    finished_next = 1'b1;
            endcase
        end

        cnt_sum    = {1'b0, count_reg} + (COUNT_W+1)'(inc);
        count_next = cnt_sum[COUNT_W] ? {COUNT_W{1'b1}} : cnt_sum[COUNT_W-1:0];

        if (clr)
        begin
            phase_next    = PH_START;
            finished_next = 1'b0;
            neg_next      = 1'b0;
            int_next      = '0;
            digit_next    = 1'b0;
            num_next      = '0;
            step_next     = '0;
            kidx_next     = '0;
            kw_next       = 1'b0;
            first_next    = '0;
            count_next    = '0;
            ovf_next      = 1'b0;
            usel_next     = UNIT_IN;
            uknown_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            finished_reg <= 1'b0;
            neg_reg      <= 1'b0;
            int_reg      <= '0;
            digit_reg    <= 1'b0;
            num_reg      <= '0;
            step_reg     <= '0;
            kidx_reg     <= '0;
            kw_reg       <= 1'b0;
            first_reg    <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            usel_reg     <= UNIT_IN;
            uknown_reg   <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            finished_reg <= finished_next;
            neg_reg      <= neg_next;
            int_reg      <= int_next;
            digit_reg    <= digit_next;
            num_reg      <= num_next;
            step_reg     <= step_next;
            kidx_reg     <= kidx_next;
            kw_reg       <= kw_next;
            first_reg    <= first_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            usel_reg     <= usel_next;
            uknown_reg   <= uknown_next;
        end
    end

    always_comb
    begin
        p.neg        = neg_reg;
        p.int_part   = int_reg;
        p.digit_seen = digit_reg;
        p.frac_num   = num_reg;
        p.den_step   = step_reg;
        p.kw_found   = kw_reg;
        p.unit_code  = uknown_reg ? usel_reg : UNIT_IN;
        p.unit_known = uknown_reg;
        p.count      = count_reg;
        p.ovf        = ovf_reg;
    end

endmodule

/* src/dtsp_alu.sv */
// Shared arithmetic unit: one registered multiplier, a wide accumulator
// and a restoring divider, one bit per cycle while stepped. Depends on dtsp_pkg.
module dtsp_alu (
    input  logic                          clk,
    input  dtsp_pkg::dtsp_ctl_t           ctl,
    input  logic [dtsp_pkg::MUL_A_W-1:0]  mul_a,
    input  logic [dtsp_pkg::MUL_B_W-1:0]  mul_b,
    input  logic [dtsp_pkg::DIV_W-1:0]    div_dividend,
    input  logic [dtsp_pkg::DVS_W-1:0]    div_divisor,
    output logic [dtsp_pkg::ACC_W-1:0]    acc,
    output logic [dtsp_pkg::PROD_W-1:0]   prod,
    output logic [dtsp_pkg::DIV_W-1:0]    quo,
    output logic [dtsp_pkg::DVS_W-1:0]    rem
);
    import dtsp_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);

        if (ctl.acc_clr)
            acc_reg <= '0;
        else if (ctl.acc_add_prod)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        else if (ctl.acc_add_quo)
            acc_reg <= acc_reg + ACC_W'(dvd_reg);

        if (ctl.div_load)
        begin
            dvd_reg <= div_dividend;
            rem_reg <= '0;
            dvs_reg <= div_divisor;
        end
        else if (ctl.div_step)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign acc  = acc_reg;
    assign prod = prod_reg;
    assign quo  = dvd_reg;
    assign rem  = rem_reg;

endmodule
